// ===== sv/assert_macros.svh =====
// Assertion macros for the resolve block's RTL files.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define VRC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");

// Checked at every rising clock edge, reset included.
`define VRC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ===== sv/vrc_pkg.sv =====
// Types, widths and constants for the visibility buffer color resolve block.
// Depends on nothing; imported by every module of the block but vrc_divider.
package vrc_pkg;

   localparam int IDX_W      = 12;
   localparam int PIX_W      = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 200;
   localparam int RSP_DATA_W = 56;

   localparam int COORD_W   = 23;
   localparam int PROJ_QW   = 42;
   localparam int PROJ_LAT  = PROJ_QW + 4;
   localparam int DIFF_W    = 24;
   localparam int PROD_W    = 48;
   localparam int EDGE_W    = 49;
   localparam int WGT_QW    = 31;
   localparam int WGT_LAT   = WGT_QW + 6;
   localparam int WGT_W     = 34;
   localparam int SHADE_LAT = 3;

   localparam logic [PROJ_QW-1:0] T_SAT = PROJ_QW'(1) << (PROJ_QW - 1);
   localparam logic [WGT_QW-1:0]  W_SAT = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VIEWPORT_X,
      CSR_VIEWPORT_Y,
      CSR_VIEWPORT_WIDTH,
      CSR_VIEWPORT_HEIGHT,
      CSR_COLORS_PRESENT,
      CSR_TRIANGLE_COUNT
   } csr_index_type;

   typedef enum logic {
      KIND_LOAD,
      KIND_RESOLVE
   } kind_type;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [WGT_W-1:0]   weight_type;

   // Channel 0 is red, channel 3 is alpha.
   typedef logic [3:0][15:0] color_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] w;
      color_type          color;
   } vertex_type;

   typedef struct packed {
      logic                 valid;
      logic [PIX_W-1:0]     px;
      logic [PIX_W-1:0]     py;
      color_type [2:0]      color;
   } side_type;

   // Quotient by three of a 12-bit slot number, exact over the whole range.
   function automatic logic [10:0] div3(input logic [IDX_W-1:0] v);
      logic [24:0] p;
      p = 25'(v) * 25'(2731);
      return p[23:13];
   endfunction

   function automatic logic [1:0] mod3(input logic [IDX_W-1:0] v);
      logic [IDX_W-1:0] t;
      t = v - IDX_W'(div3(v)) * IDX_W'(3);
      return t[1:0];
   endfunction

endpackage

// ===== sv/visibility_buffer_color_resolve_top.sv =====
// Top level of the visibility buffer color resolve block: registers, vertex banks, pipeline.
// Depends on vrc_pkg, assert_macros.svh, vrc_vertex_bank, vrc_project, vrc_weight, vrc_shade.
//
// Channel  Dir  Handshake               Word
// req      in   req_tvalid/req_tready   vertex load or pixel resolve, kind in req_tuser
// rsp      out  rsp_tvalid/rsp_tready   pixel column, row and RGBA
// csr      in   csr_we                  viewport, colors_present, triangle_count
//
// One word is accepted every cycle while req_tready is high, loads and resolves mixed freely.
// A resolve passes through the bank read, projection, weight and shade stages to rsp; the 42-step
// quotient pipeline of the projection and the 31-step one of the weights set most of the pipeline depth.
// The three corner banks are read together at the accept edge; loads write at that edge.
// Reset clears the CSR registers, the valid flags and the area-zero flags; the vertex banks need no clearing pass.
// The pipeline stalls only when a result waits at rsp and the last stage is occupied.
`include "assert_macros.svh"

module visibility_buffer_color_resolve_top #(
   parameter int MAX_TRIANGLES = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // index, clip_x, clip_y, clip_w, color_red, color_green, color_blue, color_alpha,
   // pixel_x, pixel_y, covered
   input  logic [vrc_pkg::REQ_DATA_W-1:0] req_tdata,
   // kind
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // out_pixel_x, out_pixel_y, rgba_word
   output logic [vrc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_we,
   input  logic [vrc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [vrc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import vrc_pkg::*;

   localparam int ADDR_W     = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
   localparam int VERT_DEPTH = 3 * MAX_TRIANGLES;
   localparam int TOTAL_LAT  = PROJ_LAT + WGT_LAT + SHADE_LAT;

   logic [IDX_W-1:0]   req_index;
   logic [PIX_W-1:0]   req_px;
   logic [PIX_W-1:0]   req_py;
   logic               req_covered;
   vertex_type         req_vertex;

   logic signed [31:0] vp_x_ff;
   logic signed [31:0] vp_y_ff;
   logic [30:0]        vp_w_ff;
   logic [30:0]        vp_h_ff;
   logic               colors_ff;
   logic [10:0]        tri_count_ff;

   logic               take;
   logic               en;
   logic               accept;
   logic               load_we;
   logic [1:0]         load_bank;
   logic [ADDR_W-1:0]  load_addr;
   logic [ADDR_W-1:0]  read_addr;

   logic               s0_valid_in;
   logic               s0_valid_ff;
   logic [PIX_W-1:0]   s0_px_ff;
   logic [PIX_W-1:0]   s0_py_ff;

   vertex_type         vtx [3];
   side_type           side_in;
   side_type           side_ff [TOTAL_LAT];

   logic signed [33:0] off_x;
   logic signed [33:0] off_y;
   coord_type          sx [3];
   coord_type          sy [3];
   weight_type         wt [3];
   logic               area_zero;
   logic               az_ff [SHADE_LAT];
   logic [31:0]        shade_rgba;
   logic               final_valid;

   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   assign req_index          = req_tdata[11:0];
   assign req_vertex.x       = req_tdata[43:12];
   assign req_vertex.y       = req_tdata[75:44];
   assign req_vertex.w       = req_tdata[107:76];
   assign req_vertex.color   = req_tdata[171:108];
   assign req_px             = req_tdata[183:172];
   assign req_py             = req_tdata[195:184];
   assign req_covered        = req_tdata[196];

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_x_ff      <= '0;
         vp_y_ff      <= '0;
         vp_w_ff      <= '0;
         vp_h_ff      <= '0;
         colors_ff    <= 1'b0;
         tri_count_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_VIEWPORT_X:      vp_x_ff      <= csr_wdata;
            CSR_VIEWPORT_Y:      vp_y_ff      <= csr_wdata;
            CSR_VIEWPORT_WIDTH:  vp_w_ff      <= csr_wdata[30:0];
            CSR_VIEWPORT_HEIGHT: vp_h_ff      <= csr_wdata[30:0];
            CSR_COLORS_PRESENT:  colors_ff    <= csr_wdata[0];
            CSR_TRIANGLE_COUNT:  tri_count_ff <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   assign take       = !rsp_valid_ff || rsp_tready;
   assign en         = take || !final_valid;
   assign req_tready = en;
   assign accept     = req_tvalid && en;

   assign load_bank = mod3(req_index);
   assign load_addr = ADDR_W'(div3(req_index));
   assign read_addr = ADDR_W'(req_index);
   assign load_we   = accept && (kind_type'(req_tuser) == KIND_LOAD)
                    && (32'(req_index) < VERT_DEPTH);

   for (genvar k = 0; k < 3; k++) begin : g_corner
      vrc_vertex_bank #(
         .DEPTH (MAX_TRIANGLES),
         .ADDR_W(ADDR_W)
      ) u_bank (
         .clock  (clock),
         .wr_en  (load_we && load_bank == 2'(k)),
         .wr_addr(load_addr),
         .wr_data(req_vertex),
         .rd_en  (en),
         .rd_addr(read_addr),
         .rd_data(vtx[k])
      );

      vrc_project #(
         .FLIP(1'b0)
      ) u_project_x (
         .clock (clock),
         .en    (en),
         .clip  (vtx[k].x),
         .clip_w(vtx[k].w),
         .span  (vp_w_ff),
         .offset(off_x),
         .coord (sx[k])
      );

      vrc_project #(
         .FLIP(1'b1)
      ) u_project_y (
         .clock (clock),
         .en    (en),
         .clip  (vtx[k].y),
         .clip_w(vtx[k].w),
         .span  (vp_h_ff),
         .offset(off_y),
         .coord (sy[k])
      );
   end

   assign s0_valid_in = accept && (kind_type'(req_tuser) == KIND_RESOLVE) && req_covered
                      && (req_index < {1'b0, tri_count_ff})
                      && (32'(req_index) < MAX_TRIANGLES);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= s0_valid_in;
      end
      if (en) begin
         s0_px_ff <= req_px;
         s0_py_ff <= req_py;
      end
   end

   // Q.17 offsets: twice the left or top edge plus the span.
   assign off_x = {vp_x_ff[31], vp_x_ff, 1'b0} + {3'b000, vp_w_ff};
   assign off_y = {vp_y_ff[31], vp_y_ff, 1'b0} + {3'b000, vp_h_ff};

   always_comb begin
      side_in.valid = s0_valid_ff && (vtx[0].w != '0) && (vtx[1].w != '0)
                    && (vtx[2].w != '0);
      side_in.px    = s0_px_ff;
      side_in.py    = s0_py_ff;
      for (int k = 0; k < 3; k++) begin
         side_in.color[k] = vtx[k].color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TOTAL_LAT; i++) begin
            side_ff[i].valid <= 1'b0;
         end
         for (int i = 0; i < SHADE_LAT; i++) begin
            az_ff[i] <= 1'b0;
         end
      end else if (en) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < TOTAL_LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         az_ff[0] <= area_zero;
         for (int i = 1; i < SHADE_LAT; i++) begin
            az_ff[i] <= az_ff[i-1];
         end
      end
   end

   vrc_weight u_weight (
      .clock    (clock),
      .en       (en),
      .sx       (sx),
      .sy       (sy),
      .px       (side_ff[PROJ_LAT-1].px),
      .py       (side_ff[PROJ_LAT-1].py),
      .wt       (wt),
      .area_zero(area_zero)
   );

   vrc_shade u_shade (
      .clock         (clock),
      .en            (en),
      .wt            (wt),
      .color         (side_ff[PROJ_LAT+WGT_LAT-1].color),
      .colors_present(colors_ff),
      .rgba          (shade_rgba)
   );

   assign final_valid = side_ff[TOTAL_LAT-1].valid && !az_ff[SHADE_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= final_valid;
      end
      if (take) begin
         rsp_data_ff <= {shade_rgba, side_ff[TOTAL_LAT-1].py, side_ff[TOTAL_LAT-1].px};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `VRC_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid_ff)
   `VRC_ASSERT(a_stall_blocks_req, clock, reset, (rsp_valid_ff && !rsp_tready && final_valid) |-> !req_tready)
   `VRC_ASSERT(a_front_from_resolve, clock, reset, (s0_valid_ff && $past(en)) |-> $past(req_tvalid && req_tuser))
   `VRC_ASSERT(a_white_without_colors, clock, reset, (rsp_valid_ff && !colors_ff) |-> (rsp_data_ff[55:24] == 32'hFFFFFFFF))

endmodule

// ===== sv/vrc_vertex_bank.sv =====
// One corner bank of the vertex store: one write and one registered read per cycle, each while its enable is high.
// Depends on vrc_pkg for the vertex record.
module vrc_vertex_bank #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  vrc_pkg::vertex_type wr_data,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output vrc_pkg::vertex_type rd_data
);
   import vrc_pkg::*;

   vertex_type mem [DEPTH];
   vertex_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/vrc_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a sideband lane.
// Depends on nothing beyond its parameters.
module vrc_divider #(
   parameter int NW = 64,
   parameter int DW = 32,
   parameter int QW = 42,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic [QW-1:0] out_quo,
   output logic          out_ovf,
   output logic [SW-1:0] out_side
);
   localparam int CW = (NW > DW + QW) ? NW : DW + QW;

   logic [NW-1:0] rem_ff  [QW];
   logic [DW-1:0] den_ff  [QW];
   logic [QW-1:0] quo_ff  [QW];
   logic          ovf_ff  [QW];
   logic [SW-1:0] side_ff [QW];

   logic [NW-1:0] rem_src  [QW];
   logic [DW-1:0] den_src  [QW];
   logic [QW-1:0] quo_src  [QW];
   logic          ovf_src  [QW];
   logic [SW-1:0] side_src [QW];
   logic [CW-1:0] trial    [QW];
   logic          ge       [QW];
   logic [NW-1:0] rem_in   [QW];
   logic [QW-1:0] quo_in   [QW];

   always_comb begin
      for (int i = 0; i < QW; i++) begin
         if (i == 0) begin
            rem_src[i]  = in_num;
            den_src[i]  = in_den;
            quo_src[i]  = '0;
            ovf_src[i]  = (CW'(in_num) >> QW) >= CW'(in_den);
            side_src[i] = in_side;
         end else begin
            rem_src[i]  = rem_ff[i-1];
            den_src[i]  = den_ff[i-1];
            quo_src[i]  = quo_ff[i-1];
            ovf_src[i]  = ovf_ff[i-1];
            side_src[i] = side_ff[i-1];
         end
         trial[i]  = CW'(den_src[i]) << (QW - 1 - i);
         ge[i]     = CW'(rem_src[i]) >= trial[i];
         rem_in[i] = ge[i] ? NW'(CW'(rem_src[i]) - trial[i]) : rem_src[i];
         quo_in[i] = quo_src[i] | (QW'(ge[i]) << (QW - 1 - i));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < QW; i++) begin
            rem_ff[i]  <= rem_in[i];
            den_ff[i]  <= den_src[i];
            quo_ff[i]  <= quo_in[i];
            ovf_ff[i]  <= ovf_src[i];
            side_ff[i] <= side_src[i];
         end
      end
   end

   assign out_quo  = quo_ff[QW-1];
   assign out_ovf  = ovf_ff[QW-1];
   assign out_side = side_ff[QW-1];

endmodule

// ===== sv/vrc_project.sv =====
// Projection of one clip coordinate to a Q.8 screen coordinate through the viewport.
// Depends on vrc_pkg and vrc_divider.
module vrc_project #(
   parameter logic FLIP = 1'b0
) (
   input  logic               clock,
   input  logic               en,
   input  logic signed [31:0] clip,
   input  logic signed [31:0] clip_w,
   input  logic [30:0]        span,
   input  logic signed [33:0] offset,
   output vrc_pkg::coord_type coord
);
   import vrc_pkg::*;

   logic [31:0]        mag_c_ff;
   logic [31:0]        mag_w_ff;
   logic               neg_ff;
   logic [62:0]        prod;
   logic [63:0]        num_ff;
   logic [31:0]        den_ff;
   logic               neg_num_ff;
   logic [PROJ_QW-1:0] quo;
   logic               ovf;
   logic               neg_quo;
   logic [PROJ_QW-1:0] quo_sat;
   logic signed [44:0] sum_in;
   logic signed [44:0] sum_ff;
   logic signed [44:0] round_sum;
   logic signed [35:0] shifted;
   coord_type          coord_in;
   coord_type          coord_ff;

   assign prod = mag_c_ff * span;

   always_ff @(posedge clock) begin
      if (en) begin
         mag_c_ff   <= clip[31] ? 32'(0 - clip) : clip;
         mag_w_ff   <= clip_w[31] ? 32'(0 - clip_w) : clip_w;
         neg_ff     <= clip[31] ^ clip_w[31] ^ FLIP;
         num_ff     <= 64'(prod) + 64'(mag_w_ff[31:1]);
         den_ff     <= mag_w_ff;
         neg_num_ff <= neg_ff;
      end
   end

   vrc_divider #(
      .NW(64),
      .DW(32),
      .QW(PROJ_QW),
      .SW(1)
   ) u_divider (
      .clock   (clock),
      .en      (en),
      .in_num  (num_ff),
      .in_den  (den_ff),
      .in_side (neg_num_ff),
      .out_quo (quo),
      .out_ovf (ovf),
      .out_side(neg_quo)
   );

   always_comb begin
      quo_sat   = (ovf || quo > T_SAT) ? T_SAT : quo;
      sum_in    = neg_quo ? 45'(offset) - 45'(quo_sat) : 45'(offset) + 45'(quo_sat);
      round_sum = sum_ff + 45'sd256;
      shifted   = round_sum[44:9];
      if (shifted > 36'sd4194303) begin
         coord_in = 23'sh3FFFFF;
      end else if (shifted < -36'sd4194304) begin
         coord_in = 23'sh400000;
      end else begin
         coord_in = shifted[22:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff   <= sum_in;
         coord_ff <= coord_in;
      end
   end

   assign coord = coord_ff;

endmodule

// ===== sv/vrc_weight.sv =====
// Edge functions, triangle area and the three barycentric weights in Q17.16.
// Depends on vrc_pkg and vrc_divider.
module vrc_weight (
   input  logic                clock,
   input  logic                en,
   input  vrc_pkg::coord_type  sx [3],
   input  vrc_pkg::coord_type  sy [3],
   input  logic [11:0]         px,
   input  logic [11:0]         py,
   output vrc_pkg::weight_type wt [3],
   output logic                area_zero
);
   import vrc_pkg::*;

   logic signed [DIFF_W-1:0] cx;
   logic signed [DIFF_W-1:0] cy;
   logic signed [DIFF_W-1:0] dx10_ff, dy20_ff, dy10_ff, dx20_ff;
   logic signed [DIFF_W-1:0] ux0_ff, ux1_ff, ux2_ff, vy0_ff, vy1_ff, vy2_ff;
   logic signed [PROD_W-1:0] pa1_ff, pa2_ff, p01_ff, p02_ff, p11_ff, p12_ff;
   logic signed [EDGE_W-1:0] area_ff, e0_ff, e1_ff;
   logic [EDGE_W-1:0]        mag_a, mag_e0, mag_e1;
   logic [65:0]              num0_ff, num1_ff;
   logic [EDGE_W-1:0]        den_ff;
   logic                     neg0_ff, neg1_ff, zero_ff;
   logic [WGT_QW-1:0]        quo0, quo1;
   logic                     ovf0, ovf1;
   logic [1:0]               side0;
   logic                     side1;
   logic [WGT_QW-1:0]        m0, m1;
   logic signed [31:0]       w0_ff, w1_ff;
   logic                     zero_q_ff;
   weight_type               wt_ff [3];
   logic                     zero_out_ff;

   assign cx = $signed({4'b0000, px, 8'h80});
   assign cy = $signed({4'b0000, py, 8'h80});

   always_comb begin
      mag_a  = area_ff[EDGE_W-1] ? EDGE_W'(-area_ff) : area_ff;
      mag_e0 = e0_ff[EDGE_W-1] ? EDGE_W'(-e0_ff) : e0_ff;
      mag_e1 = e1_ff[EDGE_W-1] ? EDGE_W'(-e1_ff) : e1_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx10_ff <= DIFF_W'(sx[1]) - DIFF_W'(sx[0]);
         dy20_ff <= DIFF_W'(sy[2]) - DIFF_W'(sy[0]);
         dy10_ff <= DIFF_W'(sy[1]) - DIFF_W'(sy[0]);
         dx20_ff <= DIFF_W'(sx[2]) - DIFF_W'(sx[0]);
         ux0_ff  <= DIFF_W'(sx[0]) - cx;
         ux1_ff  <= DIFF_W'(sx[1]) - cx;
         ux2_ff  <= DIFF_W'(sx[2]) - cx;
         vy0_ff  <= DIFF_W'(sy[0]) - cy;
         vy1_ff  <= DIFF_W'(sy[1]) - cy;
         vy2_ff  <= DIFF_W'(sy[2]) - cy;

         pa1_ff <= dx10_ff * dy20_ff;
         pa2_ff <= dy10_ff * dx20_ff;
         p01_ff <= ux1_ff * vy2_ff;
         p02_ff <= vy1_ff * ux2_ff;
         p11_ff <= ux2_ff * vy0_ff;
         p12_ff <= vy2_ff * ux0_ff;

         area_ff <= EDGE_W'(pa1_ff) - EDGE_W'(pa2_ff);
         e0_ff   <= EDGE_W'(p01_ff) - EDGE_W'(p02_ff);
         e1_ff   <= EDGE_W'(p11_ff) - EDGE_W'(p12_ff);

         num0_ff <= (66'(mag_e0) << 16) + 66'(mag_a >> 1);
         num1_ff <= (66'(mag_e1) << 16) + 66'(mag_a >> 1);
         den_ff  <= mag_a;
         neg0_ff <= e0_ff[EDGE_W-1] ^ area_ff[EDGE_W-1];
         neg1_ff <= e1_ff[EDGE_W-1] ^ area_ff[EDGE_W-1];
         zero_ff <= (area_ff == '0);
      end
   end

   vrc_divider #(
      .NW(66),
      .DW(EDGE_W),
      .QW(WGT_QW),
      .SW(2)
   ) u_divider0 (
      .clock   (clock),
      .en      (en),
      .in_num  (num0_ff),
      .in_den  (den_ff),
      .in_side ({zero_ff, neg0_ff}),
      .out_quo (quo0),
      .out_ovf (ovf0),
      .out_side(side0)
   );

   vrc_divider #(
      .NW(66),
      .DW(EDGE_W),
      .QW(WGT_QW),
      .SW(1)
   ) u_divider1 (
      .clock   (clock),
      .en      (en),
      .in_num  (num1_ff),
      .in_den  (den_ff),
      .in_side (neg1_ff),
      .out_quo (quo1),
      .out_ovf (ovf1),
      .out_side(side1)
   );

   assign m0 = ovf0 ? W_SAT : quo0;
   assign m1 = ovf1 ? W_SAT : quo1;

   always_ff @(posedge clock) begin
      if (en) begin
         w0_ff     <= side0[0] ? -$signed({1'b0, m0}) : $signed({1'b0, m0});
         w1_ff     <= side1 ? -$signed({1'b0, m1}) : $signed({1'b0, m1});
         zero_q_ff <= side0[1];

         wt_ff[0]    <= WGT_W'(w0_ff);
         wt_ff[1]    <= WGT_W'(w1_ff);
         wt_ff[2]    <= WGT_W'(65536) - WGT_W'(w0_ff) - WGT_W'(w1_ff);
         zero_out_ff <= zero_q_ff;
      end
   end

   assign wt        = wt_ff;
   assign area_zero = zero_out_ff;

endmodule

// ===== sv/vrc_shade.sv =====
// Color interpolation, clamping, rounding to 8 bits and RGBA packing, or all ones when colors_present is low.
// Depends on vrc_pkg.
module vrc_shade (
   input  logic                     clock,
   input  logic                     en,
   input  vrc_pkg::weight_type      wt [3],
   input  vrc_pkg::color_type [2:0] color,
   input  logic                     colors_present,
   output logic [31:0]              rgba
);
   import vrc_pkg::*;

   localparam int MUL_W = WGT_W + 16;
   localparam int SUM_W = MUL_W + 2;

   logic signed [MUL_W-1:0] prod_ff [4][3];
   logic signed [SUM_W-1:0] sum_ff  [4];
   logic [30:0]             clamped [4];
   logic [38:0]             scaled  [4];
   logic [31:0]             packed_in;
   logic [31:0]             rgba_ff;

   always_comb begin
      for (int ch = 0; ch < 4; ch++) begin
         if (sum_ff[ch] < 0) begin
            clamped[ch] = '0;
         end else if (sum_ff[ch] > SUM_W'(64'sd1073741824)) begin
            clamped[ch] = 31'h40000000;
         end else begin
            clamped[ch] = sum_ff[ch][30:0];
         end
         scaled[ch] = 39'(clamped[ch]) * 39'd255 + 39'h20000000;
         packed_in[8*ch +: 8] = scaled[ch][37:30];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int ch = 0; ch < 4; ch++) begin
            for (int k = 0; k < 3; k++) begin
               prod_ff[ch][k] <= wt[k] * $signed(color[k][ch]);
            end
            sum_ff[ch] <= SUM_W'(prod_ff[ch][0]) + SUM_W'(prod_ff[ch][1])
                        + SUM_W'(prod_ff[ch][2]);
         end
         rgba_ff <= colors_present ? packed_in : '1;
      end
   end

   assign rgba = rgba_ff;

endmodule
